// ===== design/rba_pkg.sv =====
// Shared types and constants for the rectangle blit / alpha blend block
package rba_pkg;

   localparam int MaxDimDefault = 4096;
   localparam int QueueDepth    = 4;
   localparam int PosW          = 14;   // dest (12 bits) plus a counter of up to 13 bits
   localparam int PitchW        = 16;
   localparam int OffsetW       = 29;
   localparam int CsrIndexW     = 3;
   localparam int CsrDataW      = 16;
   localparam int DimW          = 17;   // holds any clamped dimension up to 65536

   // reciprocals for exact floor division by 65025 and by 255
   localparam logic [16:0] ColorDiv    = 17'd65025;
   localparam logic [16:0] ColorRecip  = 17'd66051;  // floor(2^32 / 65025)
   localparam logic [8:0]  AlphaDiv    = 9'd255;
   localparam logic [16:0] AlphaRecip  = 17'd65793;  // floor(2^24 / 255)

   typedef enum logic [CsrIndexW-1:0] {
      CSR_ROW_PITCH    = 3'd0,
      CSR_DEST_X       = 3'd1,
      CSR_DEST_Y       = 3'd2,
      CSR_RECT_WIDTH   = 3'd3,
      CSR_RECT_HEIGHT  = 3'd4,
      CSR_BLEND_ENABLE = 3'd5
   } csr_index_type;

   // one classified pixel waiting between front and back
   typedef struct packed {
      logic [2:0][7:0]   src_color;
      logic [7:0]        src_alpha;
      logic [2:0][7:0]   dst_color;
      logic [7:0]        dst_alpha;
      logic [PosW-1:0]   row_pos;
      logic [PosW-1:0]   col_pos;
      logic [PitchW-1:0] pitch;
      logic              blend;
      logic              last;
   } rba_item_type;

endpackage

// ===== design/rba_req_if.sv =====
// Input channel: source pixel paired with the destination pixel at its place
interface rba_req_if import rba_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] src_red;
   logic [7:0] src_green;
   logic [7:0] src_blue;
   logic [7:0] src_alpha;
   logic [7:0] dst_red;
   logic [7:0] dst_green;
   logic [7:0] dst_blue;
   logic [7:0] dst_alpha;

   modport source (
      output valid, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      input  ready
   );
   modport sink (
      input  valid, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      output ready
   );
endinterface

// ===== design/rba_rsp_if.sv =====
// Result channel: destination offset and new pixel
interface rba_rsp_if import rba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OffsetW-1:0] dst_offset;
   logic [7:0]         out_red;
   logic [7:0]         out_green;
   logic [7:0]         out_blue;
   logic [7:0]         out_alpha;
   logic               last_pixel;

   modport source (
      output valid, dst_offset, out_red, out_green, out_blue, out_alpha, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, dst_offset, out_red, out_green, out_blue, out_alpha, last_pixel,
      output ready
   );
endinterface

// ===== design/rect_blit_alpha_blend.sv =====
// Rectangle blitter with copy or exact alpha-over blend, one result per input item.
// Path from input acceptance to the result: queue write, then four compute stages and
// the output register.
// Throughput: one item per clock unless the output stalls, set by the back-end
// pipeline in lockstep; a 4-entry queue keeps the input open in a stall until full.
// Reset (synchronous, active high) clears the walk counters, queue and stage valids,
// and loads pitch and origin 0, width and height 1, copy mode.
module rect_blit_alpha_blend import rba_pkg::*; #(
   parameter int MAX_DIM = MaxDimDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wr_data,
   rba_req_if.sink              req_chan,
   rba_rsp_if.source            rsp_chan
);

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_not_empty;
   rba_item_type q_push_item;
   rba_item_type q_pop_item;

   rba_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   rba_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_pop_item)
   );

   rba_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_item   (q_pop_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== design/rba_front.sv =====
// Front end: config registers, rectangle walk and item classification
module rba_front import rba_pkg::*; #(
   parameter int MAX_DIM = MaxDimDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wr_data,
   rba_req_if.sink              req_chan,
   input  logic                 q_full,
   output logic                 q_push,
   output rba_item_type         q_item
);

   localparam int CapDim = (MAX_DIM < 8192) ? MAX_DIM : 8192;
   localparam int CntW   = $clog2(CapDim);
   localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

   logic [PitchW-1:0] pitch_ff;
   logic [11:0]       dest_x_ff;
   logic [11:0]       dest_y_ff;
   logic [12:0]       width_ff;
   logic [12:0]       height_ff;
   logic              blend_ff;

   logic [CntW-1:0]   col_ff, col_in;
   logic [CntW-1:0]   row_ff, row_in;

   logic [DimW-1:0]   width_lim;
   logic [DimW-1:0]   height_lim;
   logic              col_last;
   logic              row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff  <= '0;
         dest_x_ff <= '0;
         dest_y_ff <= '0;
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         blend_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_PITCH:    pitch_ff  <= csr_wr_data;
            CSR_DEST_X:       dest_x_ff <= csr_wr_data[11:0];
            CSR_DEST_Y:       dest_y_ff <= csr_wr_data[11:0];
            CSR_RECT_WIDTH:   width_ff  <= csr_wr_data[12:0];
            CSR_RECT_HEIGHT:  height_ff <= csr_wr_data[12:0];
            CSR_BLEND_ENABLE: blend_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // a zero size acts as one, an oversize acts as the maximum
   always_comb begin
      if (width_ff == '0)
         width_lim = DimW'(1);
      else if (DimW'(width_ff) > MaxDim)
         width_lim = MaxDim;
      else
         width_lim = DimW'(width_ff);

      if (height_ff == '0)
         height_lim = DimW'(1);
      else if (DimW'(height_ff) > MaxDim)
         height_lim = MaxDim;
      else
         height_lim = DimW'(height_ff);
   end

   assign col_last = (DimW'(col_ff) + DimW'(1)) >= width_lim;
   assign row_last = (DimW'(row_ff) + DimW'(1)) >= height_lim;

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + CntW'(1);
         end else begin
            col_in = col_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      q_item.src_color = {req_chan.src_blue, req_chan.src_green, req_chan.src_red};
      q_item.src_alpha = req_chan.src_alpha;
      q_item.dst_color = {req_chan.dst_blue, req_chan.dst_green, req_chan.dst_red};
      q_item.dst_alpha = req_chan.dst_alpha;
      q_item.row_pos   = PosW'(dest_y_ff) + PosW'(row_ff);
      q_item.col_pos   = PosW'(dest_x_ff) + PosW'(col_ff);
      q_item.pitch     = pitch_ff;
      q_item.blend     = blend_ff;
      q_item.last      = col_last && row_last;
   end

endmodule

// ===== design/rba_queue.sv =====
// Short item queue between front and back
module rba_queue import rba_pkg::*; #(
   parameter int DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rba_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output rba_item_type pop_item
);

   localparam int PtrW = $clog2(DEPTH);

   rba_item_type          store_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff;
   logic [PtrW-1:0]       rd_ptr_ff;
   logic [PtrW:0]         count_ff;
   logic                  do_pop;

   assign full      = count_ff == (PtrW+1)'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_item  = store_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (push)
         store_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         if (push && !do_pop)
            count_ff <= count_ff + (PtrW+1)'(1);
         else if (do_pop && !push)
            count_ff <= count_ff - (PtrW+1)'(1);
      end
   end

endmodule

// ===== design/rba_back.sv =====
// Back end: offset arithmetic and exact alpha-over blend pipeline
module rba_back import rba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  rba_item_type q_item,
   output logic         q_pop,
   rba_rsp_if.source    rsp_chan
);

   typedef struct packed {
      logic [2:0][7:0]  src_color;
      logic [7:0]       src_alpha;
      logic [2:0][7:0]  dst_color;
      logic [2:0][15:0] prod;
      logic [15:0]      weight;
      logic [29:0]      row_mul;
      logic [PosW-1:0]  col_pos;
      logic             blend;
      logic             last;
   } s1_type;

   typedef struct packed {
      logic [2:0][7:0]     src_color;
      logic [7:0]          src_alpha;
      logic [2:0][23:0]    num_c;
      logic [15:0]         num_a;
      logic [OffsetW-1:0]  offset;
      logic                blend;
      logic                last;
   } s2_type;

   typedef struct packed {
      logic [2:0][7:0]     src_color;
      logic [7:0]          src_alpha;
      logic [2:0][23:0]    num_c;
      logic [15:0]         num_a;
      logic [2:0][40:0]    est_c;
      logic [32:0]         est_a;
      logic [OffsetW-1:0]  offset;
      logic                blend;
      logic                last;
   } s3_type;

   typedef struct packed {
      logic [2:0][7:0]     src_color;
      logic [7:0]          src_alpha;
      logic [2:0][7:0]     quo_c;
      logic [2:0][16:0]    rem_c;
      logic [7:0]          quo_a;
      logic [8:0]          rem_a;
      logic [OffsetW-1:0]  offset;
      logic                blend;
      logic                last;
   } s4_type;

   logic   adv;
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, out_vld_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;

   logic [OffsetW-1:0] out_offset_ff;
   logic [2:0][7:0]    out_color_ff, out_color_in;
   logic [7:0]         out_alpha_ff, out_alpha_in;
   logic               out_last_ff;

   // whole pipeline holds while a finished item waits at the output
   assign adv   = !out_vld_ff || rsp_chan.ready;
   assign q_pop = adv;

   always_comb begin
      s1_in.src_color = q_item.src_color;
      s1_in.src_alpha = q_item.src_alpha;
      s1_in.dst_color = q_item.dst_color;
      s1_in.weight    = 16'(8'd255 - q_item.src_alpha) * 16'(q_item.dst_alpha);
      for (int i = 0; i < 3; i++)
         s1_in.prod[i] = 16'(q_item.src_color[i]) * 16'(q_item.src_alpha);
      s1_in.row_mul   = 30'(q_item.row_pos) * 30'(q_item.pitch);
      s1_in.col_pos   = q_item.col_pos;
      s1_in.blend     = q_item.blend;
      s1_in.last      = q_item.last;
   end

   always_comb begin
      s2_in.src_color = s1_ff.src_color;
      s2_in.src_alpha = s1_ff.src_alpha;
      for (int i = 0; i < 3; i++)
         s2_in.num_c[i] = {s1_ff.prod[i], 8'h00} - 24'(s1_ff.prod[i])
                        + 24'(s1_ff.weight) * 24'(s1_ff.dst_color[i]);
      s2_in.num_a  = {s1_ff.src_alpha, 8'h00} - 16'(s1_ff.src_alpha) + s1_ff.weight;
      s2_in.offset = OffsetW'(s1_ff.row_mul + 30'({s1_ff.col_pos, 2'b00}));
      s2_in.blend  = s1_ff.blend;
      s2_in.last   = s1_ff.last;
   end

   always_comb begin
      s3_in.src_color = s2_ff.src_color;
      s3_in.src_alpha = s2_ff.src_alpha;
      s3_in.num_c     = s2_ff.num_c;
      s3_in.num_a     = s2_ff.num_a;
      for (int i = 0; i < 3; i++)
         s3_in.est_c[i] = 41'(s2_ff.num_c[i]) * 41'(ColorRecip);
      s3_in.est_a  = 33'(s2_ff.num_a) * 33'(AlphaRecip);
      s3_in.offset = s2_ff.offset;
      s3_in.blend  = s2_ff.blend;
      s3_in.last   = s2_ff.last;
   end

   // estimate is low by at most one; keep the remainder for the fix-up
   always_comb begin
      s4_in.src_color = s3_ff.src_color;
      s4_in.src_alpha = s3_ff.src_alpha;
      for (int i = 0; i < 3; i++) begin
         s4_in.quo_c[i] = s3_ff.est_c[i][39:32];
         s4_in.rem_c[i] = 17'(s3_ff.num_c[i]
                              - 24'(s3_ff.est_c[i][39:32]) * 24'(ColorDiv));
      end
      s4_in.quo_a  = s3_ff.est_a[31:24];
      s4_in.rem_a  = 9'(s3_ff.num_a - 16'(s3_ff.est_a[31:24]) * 16'(AlphaDiv));
      s4_in.offset = s3_ff.offset;
      s4_in.blend  = s3_ff.blend;
      s4_in.last   = s3_ff.last;
   end

   always_comb begin
      if (s4_ff.blend) begin
         for (int i = 0; i < 3; i++)
            out_color_in[i] = s4_ff.quo_c[i] + 8'(s4_ff.rem_c[i] >= ColorDiv);
         out_alpha_in = s4_ff.quo_a + 8'(s4_ff.rem_a >= AlphaDiv);
      end else begin
         out_color_in = s4_ff.src_color;
         out_alpha_in = s4_ff.src_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= q_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         out_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff         <= s1_in;
         s2_ff         <= s2_in;
         s3_ff         <= s3_in;
         s4_ff         <= s4_in;
         out_offset_ff <= s4_ff.offset;
         out_color_ff  <= out_color_in;
         out_alpha_ff  <= out_alpha_in;
         out_last_ff   <= s4_ff.last;
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.dst_offset = out_offset_ff;
   assign rsp_chan.out_red    = out_color_ff[0];
   assign rsp_chan.out_green  = out_color_ff[1];
   assign rsp_chan.out_blue   = out_color_ff[2];
   assign rsp_chan.out_alpha  = out_alpha_ff;
   assign rsp_chan.last_pixel = out_last_ff;

endmodule
